// ===== rtl/uer_pkg.sv =====
// Package for the ultrasonic echo ranger: shared widths, register indexes,
// arithmetic constants and the per-tick result record. No dependencies.
package uer_pkg;

  localparam int unsigned CntW     = 17;
  localparam int unsigned TicksW   = 16;
  localparam int unsigned HeightW  = 8;
  localparam int unsigned DistW    = 11;
  localparam int unsigned FillW    = 7;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 16;

  localparam int unsigned DivDvdW  = CntW;
  localparam int unsigned DivDvsW  = HeightW;
  localparam int unsigned DivCntW  = $clog2(DivDvdW + 1);

  localparam int unsigned RecipW     = 18;
  localparam int unsigned ProdW      = CntW + RecipW;
  localparam int unsigned RecipShift = 23;

  localparam logic [CfgIdxW-1:0] RegTrigLow  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegTrigHigh = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegTimeout  = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegHeight   = CfgIdxW'(3);

  localparam logic [TicksW-1:0]  TrigLowRst  = TicksW'(2000);
  localparam logic [TicksW-1:0]  TrigHighRst = TicksW'(10000);
  localparam logic [TicksW-1:0]  TimeoutRst  = TicksW'(50000);
  localparam logic [HeightW-1:0] HeightRst   = HeightW'(15);

  localparam logic [DivDvsW-1:0] UsPerCm  = DivDvsW'(58);
  localparam logic [FillW-1:0]   FillFull = FillW'(100);

  // 2^23 / 58 rounded up. The product shifted right by 23 gives width / 58
  // exactly for every width below 2^17.
  localparam logic [ProdW-1:0]   RecipUsPerCm = ProdW'(144632);

  typedef struct packed {
    logic            trigger;
    logic            busy;
    logic            done;
    logic            timed_out;
    logic            measured;
    logic [CntW-1:0] width;
  } tick_res_t;

endpackage

// ===== rtl/uer_divider.sv =====
// Restoring divider for the echo ranger, one quotient bit per cycle.
// Depends on uer_pkg for its operand widths.
module uer_divider (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [uer_pkg::DivDvdW-1:0]  dividend_i,
  input  logic [uer_pkg::DivDvsW-1:0]  divisor_i,
  output logic                         busy_o,
  output logic                         done_o,
  output logic [uer_pkg::DivDvdW-1:0]  quotient_o
);

  logic [uer_pkg::DivDvdW-1:0] work_q;
  logic [uer_pkg::DivDvsW-1:0] rem_q;
  logic [uer_pkg::DivCntW-1:0] cnt_q;
  logic                        busy_q;
  logic                        done_q;

  logic [uer_pkg::DivDvsW:0]   rem_sh;
  logic [uer_pkg::DivDvsW:0]   rem_sub;
  logic                        q_bit;

  assign rem_sh  = {rem_q, work_q[uer_pkg::DivDvdW-1]};
  assign rem_sub = rem_sh - {1'b0, divisor_i};
  assign q_bit   = (rem_sh >= {1'b0, divisor_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= uer_pkg::DivCntW'(uer_pkg::DivDvdW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - uer_pkg::DivCntW'(1);
        if (cnt_q == uer_pkg::DivCntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      work_q <= dividend_i;
      rem_q  <= '0;
    end else if (busy_q) begin
      work_q <= {work_q[uer_pkg::DivDvdW-2:0], q_bit};
      rem_q  <= q_bit ? rem_sub[uer_pkg::DivDvsW-1:0] : rem_sh[uer_pkg::DivDvsW-1:0];
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = work_q;

endmodule

// ===== rtl/uer_timing.sv =====
// Trigger and echo timing sequencer of the echo ranger: phase and tick counter.
// Depends on uer_pkg for widths and the per-tick result record.
module uer_timing (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic                          start_req_i,
  input  logic                          echo_i,
  input  logic [uer_pkg::TicksW-1:0]    trig_low_ticks_i,
  input  logic [uer_pkg::TicksW-1:0]    trig_high_ticks_i,
  input  logic [uer_pkg::TicksW-1:0]    timeout_ticks_i,
  output uer_pkg::tick_res_t            res_o
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TRIG_LOW,
    PH_TRIG_HIGH,
    PH_WAIT_RISE,
    PH_MEASURE
  } phase_e;

  phase_e                     phase_q, phase_d, phase_eff;
  logic [uer_pkg::CntW-1:0]   cnt_q, cnt_d, cnt_eff, cnt_inc;

  always_comb begin
    phase_eff = phase_q;
    cnt_eff   = cnt_q;
    if (phase_q == PH_IDLE && start_req_i) begin
      phase_eff = PH_TRIG_LOW;
      cnt_eff   = '0;
    end
    cnt_inc = cnt_eff + uer_pkg::CntW'(1);

    phase_d         = phase_eff;
    cnt_d           = cnt_eff;
    res_o           = '0;
    res_o.width     = cnt_inc;
    unique case (phase_eff)
      PH_IDLE: begin
        cnt_d = '0;
      end
      PH_TRIG_LOW: begin
        cnt_d = cnt_inc;
        if (cnt_inc >= {1'b0, trig_low_ticks_i}) begin
          phase_d = PH_TRIG_HIGH;
          cnt_d   = '0;
        end
      end
      PH_TRIG_HIGH: begin
        res_o.trigger = 1'b1;
        cnt_d         = cnt_inc;
        if (cnt_inc >= {1'b0, trig_high_ticks_i}) begin
          phase_d = PH_WAIT_RISE;
          cnt_d   = '0;
        end
      end
      PH_WAIT_RISE: begin
        if (echo_i) begin
          phase_d = PH_MEASURE;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_inc;
          if (cnt_inc > {1'b0, timeout_ticks_i}) begin
            res_o.done      = 1'b1;
            res_o.timed_out = 1'b1;
            phase_d         = PH_IDLE;
            cnt_d           = '0;
          end
        end
      end
      PH_MEASURE: begin
        cnt_d = cnt_inc;
        if (!echo_i) begin
          res_o.done     = 1'b1;
          res_o.measured = 1'b1;
          phase_d        = PH_IDLE;
          cnt_d          = '0;
        end else if (cnt_inc > {1'b0, timeout_ticks_i}) begin
          res_o.done      = 1'b1;
          res_o.timed_out = 1'b1;
          phase_d         = PH_IDLE;
          cnt_d           = '0;
        end
      end
      default: begin
        phase_d = PH_IDLE;
        cnt_d   = '0;
      end
    endcase
    res_o.busy = (phase_d != PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

`ifndef SYNTH
  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.done |-> !res_o.busy)
    else $error("finishing tick still reports busy");
  a_measure_or_timeout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.done |-> (res_o.measured != res_o.timed_out))
    else $error("finishing tick is neither a measurement nor a timeout");
  a_hold_without_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(cnt_q))
    else $error("tick counter moved without a tick");
`endif

endmodule

// ===== rtl/ultrasonic_echo_ranger.sv =====
// Ultrasonic echo ranger top level: handshakes, registers, result sequencer.
// Depends on uer_pkg, uer_timing and uer_divider.
//
// Each input request is one microsecond tick and yields exactly one result.
// A tick that yields no new distance passes through the evaluate and output
// states before the next request can be taken. A tick on which the echo falls
// gets its distance (width / 58) from a multiply by a scaled reciprocal in a
// distance state; when the bin height is nonzero and the distance is within
// it, the 17-step divider also forms the fill percentage in a fill state. New
// ticks are taken only while the sequencer is idle; a finished result waits in
// the output register without stalling the next tick, and a full output
// register holds the sequencer until it drains. Configuration writes are
// always accepted.
module ultrasonic_echo_ranger (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // Bit 0 start_req, bit 1 echo.
  input  logic [7:0]                     s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // From bit 0: trigger, busy_res, done_res, timed_out, distance_cm[10:0],
  // fill_percent[6:0], two zero bits.
  output logic [23:0]                    m_axis_tdata,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [uer_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [uer_pkg::CfgDataW-1:0]   cfg_data_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_DIST,
    S_FILL,
    S_OUT
  } seq_e;

  seq_e                            state_q;
  logic [uer_pkg::TicksW-1:0]      trig_low_q, trig_high_q, timeout_q;
  logic [uer_pkg::HeightW-1:0]     height_q;
  uer_pkg::tick_res_t              tick_res, tick_q;
  logic [uer_pkg::DistW-1:0]       dist_q;
  logic [uer_pkg::FillW-1:0]       fill_q;
  logic                            out_valid_q;
  logic [23:0]                     out_data_q;
  logic                            div_start_q;
  logic [uer_pkg::DivDvdW-1:0]     div_dvd_q;
  logic [uer_pkg::DivDvsW-1:0]     div_dvs_q;
  logic                            div_busy, div_done;
  logic [uer_pkg::DivDvdW-1:0]     div_quot;
  logic                            in_accept;
  logic [uer_pkg::ProdW-1:0]       width_ext, dist_prod;
  logic [uer_pkg::DistW-1:0]       quot_dist;
  logic [uer_pkg::DivDvdW-1:0]     dist_ext, dist_x100;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  uer_timing u_timing (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .step_i            (in_accept),
    .start_req_i       (s_axis_tdata[0]),
    .echo_i            (s_axis_tdata[1]),
    .trig_low_ticks_i  (trig_low_q),
    .trig_high_ticks_i (trig_high_q),
    .timeout_ticks_i   (timeout_q),
    .res_o             (tick_res)
  );

  uer_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (div_dvd_q),
    .divisor_i  (div_dvs_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  assign width_ext = uer_pkg::ProdW'(tick_q.width);
  assign dist_prod = width_ext * uer_pkg::RecipUsPerCm;
  assign quot_dist = dist_prod[uer_pkg::RecipShift +: uer_pkg::DistW];
  assign dist_ext  = uer_pkg::DivDvdW'(dist_q);
  assign dist_x100 = (dist_ext << 6) + (dist_ext << 5) + (dist_ext << 2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_low_q  <= uer_pkg::TrigLowRst;
      trig_high_q <= uer_pkg::TrigHighRst;
      timeout_q   <= uer_pkg::TimeoutRst;
      height_q    <= uer_pkg::HeightRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        uer_pkg::RegTrigLow:  trig_low_q  <= cfg_data_i;
        uer_pkg::RegTrigHigh: trig_high_q <= cfg_data_i;
        uer_pkg::RegTimeout:  timeout_q   <= cfg_data_i;
        uer_pkg::RegHeight:   height_q    <= cfg_data_i[uer_pkg::HeightW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      tick_q <= tick_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      dist_q      <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      div_start_q <= 1'b0;
      div_dvd_q   <= '0;
      div_dvs_q   <= '0;
    end else begin
      div_start_q <= 1'b0;
      if (out_valid_q && m_axis_tready && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            state_q <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (tick_q.measured) begin
            dist_q  <= quot_dist;
            state_q <= S_DIST;
          end else begin
            if (tick_q.timed_out) begin
              dist_q <= '0;
              fill_q <= '0;
            end
            state_q <= S_OUT;
          end
        end
        S_DIST: begin
          if (height_q != '0 && dist_q <= uer_pkg::DistW'(height_q)) begin
            div_dvd_q   <= dist_x100;
            div_dvs_q   <= height_q;
            div_start_q <= 1'b1;
            state_q     <= S_FILL;
          end else begin
            fill_q  <= '0;
            state_q <= S_OUT;
          end
        end
        S_FILL: begin
          if (div_done) begin
            fill_q  <= uer_pkg::FillFull - div_quot[uer_pkg::FillW-1:0];
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {2'b00, fill_q, dist_q, tick_q.timed_out, tick_q.done,
                            tick_q.busy, tick_q.trigger};
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef SYNTH
  a_ready_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !div_busy)
    else $error("input taken while the divider is working");
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !s_axis_tready)
    else $error("second tick taken before the first result was built");
  a_timeout_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tdata[2] && !m_axis_tdata[1])
    else $error("timeout flag without a finished measurement");
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[21:15] <= uer_pkg::FillFull))
    else $error("fill percentage above one hundred");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for ultrasonic_echo_ranger: drives microsecond ticks over the
// stream ports, predicts every per-tick reading in a scoreboard class and compares.
// Depends on uer_pkg and the ultrasonic_echo_ranger RTL.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned ItemsTarget    = 1820;
  localparam int unsigned LongHoldAt     = 600;
  localparam int unsigned LongHoldCycles = 400;
  localparam int unsigned SettleCycles   = 64;
  localparam int unsigned CycleLimit     = 2000000;
  localparam logic [uer_pkg::CfgIdxW-1:0] RegUnused =
    uer_pkg::RegHeight + uer_pkg::CfgIdxW'(1);

  typedef struct packed {
    logic [1:0]                spare;
    logic [uer_pkg::FillW-1:0] fill;
    logic [uer_pkg::DistW-1:0] distance;
    logic                      timed_out;
    logic                      done;
    logic                      busy;
    logic                      trigger;
  } reading_t;

  class ranger_scoreboard;
    typedef enum logic [2:0] {
      PhIdle, PhTrigLow, PhTrigHigh, PhWaitRise, PhMeasure
    } phase_e;

    logic [uer_pkg::TicksW-1:0]  low_ticks;
    logic [uer_pkg::TicksW-1:0]  high_ticks;
    logic [uer_pkg::TicksW-1:0]  timeout_ticks;
    logic [uer_pkg::HeightW-1:0] height;
    phase_e                      phase;
    logic [uer_pkg::CntW-1:0]    ticks;
    logic [uer_pkg::DistW-1:0]   last_dist;
    logic [uer_pkg::FillW-1:0]   last_fill;
    reading_t                    pending_readings[$];
    int unsigned                 accepted;
    int unsigned                 errors;

    function new();
      low_ticks     = uer_pkg::TrigLowRst;
      high_ticks    = uer_pkg::TrigHighRst;
      timeout_ticks = uer_pkg::TimeoutRst;
      height        = uer_pkg::HeightRst;
      phase         = PhIdle;
      ticks         = '0;
      last_dist     = '0;
      last_fill     = '0;
      accepted      = 0;
      errors        = 0;
    endfunction

    function void write_reg(logic [uer_pkg::CfgIdxW-1:0] idx,
                            logic [uer_pkg::CfgDataW-1:0] val);
      case (idx)
        uer_pkg::RegTrigLow:  low_ticks = val;
        uer_pkg::RegTrigHigh: high_ticks = val;
        uer_pkg::RegTimeout:  timeout_ticks = val;
        uer_pkg::RegHeight:   height = val[uer_pkg::HeightW-1:0];
        default: ;
      endcase
    endfunction

    function void close_measurement(logic [uer_pkg::CntW-1:0] width, bit expired);
      int unsigned d;
      d = width / uer_pkg::UsPerCm;
      if (expired) begin
        last_dist = '0;
        last_fill = '0;
      end else begin
        last_dist = d[uer_pkg::DistW-1:0];
        if (height != 0 && d <= height) begin
          last_fill = uer_pkg::FillW'(uer_pkg::FillFull - (d * uer_pkg::FillFull) / height);
        end else begin
          last_fill = '0;
        end
      end
      phase = PhIdle;
      ticks = '0;
    endfunction

    function void predict_tick(logic start_bit, logic echo_bit);
      reading_t r;
      r = '0;
      accepted++;
      if (phase == PhIdle && start_bit) begin
        phase = PhTrigLow;
        ticks = '0;
      end
      case (phase)
        PhTrigLow: begin
          ticks++;
          if (ticks >= low_ticks) begin
            phase = PhTrigHigh;
            ticks = '0;
          end
        end
        PhTrigHigh: begin
          r.trigger = 1'b1;
          ticks++;
          if (ticks >= high_ticks) begin
            phase = PhWaitRise;
            ticks = '0;
          end
        end
        PhWaitRise: begin
          if (echo_bit) begin
            phase = PhMeasure;
            ticks = '0;
          end else begin
            ticks++;
            if (ticks > timeout_ticks) begin
              r.done = 1'b1;
              r.timed_out = 1'b1;
              close_measurement('0, 1'b1);
            end
          end
        end
        PhMeasure: begin
          ticks++;
          if (!echo_bit) begin
            r.done = 1'b1;
            close_measurement(ticks, 1'b0);
          end else if (ticks > timeout_ticks) begin
            r.done = 1'b1;
            r.timed_out = 1'b1;
            close_measurement('0, 1'b1);
          end
        end
        default: ;
      endcase
      r.busy     = (phase != PhIdle);
      r.distance = last_dist;
      r.fill     = last_fill;
      pending_readings.push_back(r);
    endfunction

    function int unsigned pending();
      return pending_readings.size();
    endfunction

    function void compare_field(string name, logic [uer_pkg::DistW-1:0] want,
                                logic [uer_pkg::DistW-1:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [23:0] raw);
      reading_t got;
      reading_t want;
      got = reading_t'(raw);
      if (pending_readings.size() == 0) begin
        errors++;
        $display("%0t: reading %h arrived, expected none", $time, raw);
        return;
      end
      want = pending_readings.pop_front();
      compare_field("trigger", uer_pkg::DistW'(want.trigger), uer_pkg::DistW'(got.trigger));
      compare_field("busy", uer_pkg::DistW'(want.busy), uer_pkg::DistW'(got.busy));
      compare_field("done", uer_pkg::DistW'(want.done), uer_pkg::DistW'(got.done));
      compare_field("timed_out", uer_pkg::DistW'(want.timed_out),
                    uer_pkg::DistW'(got.timed_out));
      compare_field("distance_cm", want.distance, got.distance);
      compare_field("fill_percent", uer_pkg::DistW'(want.fill), uer_pkg::DistW'(got.fill));
      compare_field("padding", uer_pkg::DistW'(want.spare), uer_pkg::DistW'(got.spare));
    endfunction
  endclass

  logic                         clk_i;
  logic                         rst_ni;
  logic                         s_axis_tvalid;
  logic                         s_axis_tready;
  logic [7:0]                   s_axis_tdata;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready;
  logic [23:0]                  m_axis_tdata;
  logic                         cfg_valid_i;
  logic                         cfg_ready_o;
  logic [uer_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [uer_pkg::CfgDataW-1:0] cfg_data_i;

  ranger_scoreboard sb;
  bit               steady;
  int unsigned      cycles;

  ultrasonic_echo_ranger uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [uer_pkg::CfgDataW-1:0] pick_trig();
    int unsigned r;
    r = $urandom_range(0, 29);
    if (r == 0) return 16'hFFFF;
    if (r < 4) return '0;
    return uer_pkg::CfgDataW'($urandom_range(1, 6));
  endfunction

  function automatic logic [uer_pkg::CfgDataW-1:0] pick_timeout();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return 16'hFFFF;
    if (r < 5) return uer_pkg::CfgDataW'($urandom_range(1, 20));
    return uer_pkg::CfgDataW'($urandom_range(21, 400));
  endfunction

  function automatic logic [uer_pkg::CfgDataW-1:0] pick_height();
    int unsigned r;
    logic [uer_pkg::HeightW-1:0] h;
    r = $urandom_range(0, 9);
    if (r == 0) h = '0;
    else if (r == 1) h = '1;
    else h = uer_pkg::HeightW'($urandom_range(1, 8));
    return {8'($urandom_range(0, 255)), h};
  endfunction

  // Leaves tvalid high after acceptance unless a gap follows, so that a
  // back-to-back request never sees tvalid dropped and raised in one step.
  task automatic send_tick(input logic start_bit, input logic echo_bit);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, echo_bit, start_bit};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.predict_tick(start_bit, echo_bit);
    gap = (steady || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [uer_pkg::CfgIdxW-1:0] idx,
                           input logic [uer_pkg::CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, val);
  endtask

  task automatic reconfigure();
    if ($urandom_range(0, 1) != 0) write_reg(uer_pkg::RegTrigLow, pick_trig());
    if ($urandom_range(0, 1) != 0) write_reg(uer_pkg::RegTrigHigh, pick_trig());
    if ($urandom_range(0, 1) != 0) write_reg(uer_pkg::RegTimeout, pick_timeout());
    if ($urandom_range(0, 1) != 0) write_reg(uer_pkg::RegHeight, pick_height());
    if ($urandom_range(0, 19) == 0) begin
      write_reg(RegUnused, uer_pkg::CfgDataW'($urandom()));
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_measurement();
    int unsigned lead;
    int unsigned rise;
    int unsigned hcap;
    int unsigned d;
    int unsigned w;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 20)) begin
        send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
      return;
    end
    lead = (sb.low_ticks == 0 ? 1 : sb.low_ticks) - 1 +
           (sb.high_ticks == 0 ? 1 : sb.high_ticks);
    if (lead > 40) lead = 40;
    rise = $urandom_range(0, sb.timeout_ticks < 30 ? sb.timeout_ticks + 2 : 30);
    hcap = sb.height > 8 ? 8 : sb.height;
    d = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(0, hcap + 1);
    w = 58 * d + $urandom_range(d == 0 ? 1 : 0, 57);
    send_tick(1'b1, 1'($urandom_range(0, 1)));
    repeat (lead) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    repeat (rise) send_tick(1'($urandom_range(0, 1)), 1'b0);
    repeat (w) send_tick(1'($urandom_range(0, 1)), 1'b1);
    send_tick(1'($urandom_range(0, 1)), 1'b0);
    repeat ($urandom_range(0, 2)) send_tick(1'b0, 1'($urandom_range(0, 1)));
  endtask

  initial begin : sink
    int unsigned stall_left;
    bit          long_hold_done;
    stall_left     = 0;
    long_hold_done = 1'b0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if (!long_hold_done && sb.accepted >= LongHoldAt) begin
        long_hold_done = 1'b1;
        stall_left     = LongHoldCycles;
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if (!steady && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        stall_left = pick_gap();
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    sb     = new();
    steady = 1'b0;
    cycles = 0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= '0;
    cfg_data_i    <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Idle ticks, then a start that leaves the block inside a long trigger-low phase.
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
    wait_drain();

    // Shrinking the low count mid-phase ends it on the next tick; zero counts and
    // a zero timeout give one-tick phases and immediate timeouts on rise and fall.
    write_reg(uer_pkg::RegTrigLow, 16'd1);
    write_reg(uer_pkg::RegTrigHigh, '0);
    write_reg(uer_pkg::RegTimeout, '0);
    write_reg(uer_pkg::RegHeight, '0);
    cfg_valid_i <= 1'b0;
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
    wait_drain();

    // A one-tick pulse with a zero bin height, then with the tallest bin.
    write_reg(uer_pkg::RegTimeout, 16'hFFFF);
    write_reg(uer_pkg::RegTrigLow, '0);
    write_reg(RegUnused, 16'h5A5A);
    cfg_valid_i <= 1'b0;
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    wait_drain();
    write_reg(uer_pkg::RegHeight, 16'hABFF);
    cfg_valid_i <= 1'b0;
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);

    while (sb.accepted < ItemsTarget) begin
      wait_drain();
      steady = ($urandom_range(0, 5) == 0);
      reconfigure();
      repeat ($urandom_range(1, 4)) begin
        if (sb.accepted < ItemsTarget) run_measurement();
      end
    end

    wait_drain();
    repeat (SettleCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
